>>> rtl/bfiq_pkg.sv
//------------------------------------------------------------------------------
// bfiq_pkg
// Shared constants for the bloom filter insert/query core.
//------------------------------------------------------------------------------
package bfiq_pkg;
	localparam logic [31:0] MIX_M     = 32'h5bd1e995;
	localparam logic [31:0] HASH_SEED = 32'hbc9f1d34;
	localparam logic [20:0] COUNT_MAX = 21'h1FFFFF;

	localparam logic [1:0] REG_HASH_COUNT = 2'd0;
	localparam logic [1:0] REG_BIT_COUNT  = 2'd1;
	localparam logic [1:0] REG_CAPACITY   = 2'd2;
endpackage

>>> rtl/bfiq_ram.sv
//------------------------------------------------------------------------------
// bfiq_ram
// Generic single-port synchronous RAM, registered read.
//------------------------------------------------------------------------------
module bfiq_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

>>> rtl/bloom_filter_insert_query_core.sv
//------------------------------------------------------------------------------
// bloom_filter_insert_query_core
// Bloom filter with MurmurHash2 keys, bit store in one synchronous RAM.
//------------------------------------------------------------------------------
// channel | direction | handshake          | payload
// in      | input     | valid / stall      | opcode, key_byte, key_length, last
// out     | output    | valid / stall      | answer, was_check
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A request that does not complete a 32-bit word is absorbed in ST_IDLE. One
// that does is loaded and multiplied there, mixed in ST_K1 and folded into the
// hash in ST_K2. After a last request the hash is finished in ST_F1 to ST_F3;
// each probe is then a 32-step restoring modulo, a RAM read and a check or
// write-back. After reset a clearing pass writes all MAX_BITS entries before
// the first item is taken. The result waits in an output register and
// in_stall stays high until it is taken.
module bloom_filter_insert_query_core #(
	parameter int MAX_BITS    = 65536,
	parameter int MAX_KEY_LEN = 256,
	parameter int MAX_PROBES  = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [7:0]  key_byte,
	input  logic [8:0]  key_length,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        answer,
	output logic        was_check,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import bfiq_pkg::*;

	localparam int AW = $clog2(MAX_BITS);
	localparam int BW = $clog2(MAX_KEY_LEN + 1);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_K1    = 4'd2;
	localparam logic [3:0] ST_K2    = 4'd3;
	localparam logic [3:0] ST_FOLD  = 4'd4;
	localparam logic [3:0] ST_F1    = 4'd5;
	localparam logic [3:0] ST_F2    = 4'd6;
	localparam logic [3:0] ST_F3    = 4'd7;
	localparam logic [3:0] ST_MOD   = 4'd8;
	localparam logic [3:0] ST_RD    = 4'd9;
	localparam logic [3:0] ST_CHK   = 4'd10;
	localparam logic [3:0] ST_DONE  = 4'd11;

	logic [3:0]    state_q;
	logic [4:0]    hash_count_q;
	logic [16:0]   bit_count_q;
	logic [20:0]   capacity_q;
	logic [31:0]   hash_q, word_q, k_q, h_q, delta_q;
	logic [BW-1:0] seen_q;
	logic [20:0]   count_q;
	logic          op_q, last_q, ans_q, add_ok_q;
	logic [4:0]    probe_q;
	logic [AW:0]   clr_q;
	logic [32:0]   rem_q;
	logic [31:0]   quo_q;
	logic [5:0]    step_q;
	logic          ov_q, ans_out_q, chk_out_q;

	logic [4:0]    probes;
	logic [AW:0]   modulus;
	logic          ram_we, ram_wd, ram_rd;
	logic [AW-1:0] ram_a;
	logic          absorb;
	logic [1:0]    pos;
	logic [31:0]   wbuf, kfin;
	logic [32:0]   rem_sh;

	function automatic logic opcode_ok(input logic op, input logic [20:0] cnt,
			input logic [20:0] cap);
		return op || !(cnt > cap);
	endfunction

	assign probes = (hash_count_q > 5'(MAX_PROBES)) ? 5'(MAX_PROBES) : hash_count_q;
	always_comb begin
		if (bit_count_q == '0 || 32'(bit_count_q) > 32'(MAX_BITS))
			modulus = (AW+1)'(MAX_BITS);
		else
			modulus = (AW+1)'(bit_count_q);
	end

	assign in_stall  = (state_q != ST_IDLE) || ov_q;
	assign cfg_ready = 1'b1;
	assign out_valid = ov_q;
	assign answer    = ans_out_q;
	assign was_check = chk_out_q;

	assign absorb = (32'(seen_q) < 32'(key_length)) && (32'(seen_q) < 32'(MAX_KEY_LEN));
	assign pos    = seen_q[1:0];
	always_comb begin
		wbuf = word_q;
		unique case (pos)
			2'd0: wbuf[7:0]   = key_byte;
			2'd1: wbuf[15:8]  = key_byte;
			2'd2: wbuf[23:16] = key_byte;
			default: wbuf[31:24] = key_byte;
		endcase
	end
	assign kfin   = k_q ^ (k_q >> 24);
	assign rem_sh = {rem_q[31:0], quo_q[31]};

	always_comb begin
		ram_we = 1'b0;
		ram_wd = 1'b0;
		ram_a  = rem_q[AW-1:0];
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
			ram_a  = clr_q[AW-1:0];
		end else if (state_q == ST_CHK && !op_q) begin
			ram_we = 1'b1;
			ram_wd = 1'b1;
		end
	end

	bfiq_ram #(.WIDTH(1), .DEPTH(MAX_BITS)) u_bits (
		.clk(clk), .we(ram_we), .addr(ram_a), .wdata(ram_wd), .rdata(ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_count_q <= 5'd7;
			bit_count_q  <= 17'd65536;
			capacity_q   <= 21'd4096;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HASH_COUNT: hash_count_q <= cfg_data[4:0];
				REG_BIT_COUNT:  bit_count_q  <= cfg_data[16:0];
				REG_CAPACITY:   capacity_q   <= cfg_data[20:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			hash_q  <= '0;
			word_q  <= '0;
			seen_q  <= '0;
			count_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (ov_q && !out_stall)
				ov_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(MAX_BITS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid && !ov_q) begin
						op_q   <= opcode;
						last_q <= last;
						if (seen_q == '0)
							hash_q <= HASH_SEED ^ 32'(key_length);
						if (absorb) begin
							seen_q <= seen_q + 1'b1;
							if (pos == 2'd3) begin
								k_q     <= wbuf * MIX_M;
								word_q  <= '0;
								state_q <= ST_K1;
							end else begin
								word_q  <= wbuf;
								state_q <= last ? ST_F1 : ST_IDLE;
							end
						end else begin
							state_q <= last ? ST_F1 : ST_IDLE;
						end
					end
				end
				ST_K1: begin
					k_q     <= kfin * MIX_M;
					hash_q  <= hash_q * MIX_M;
					state_q <= ST_K2;
				end
				ST_K2: begin
					hash_q  <= hash_q ^ k_q;
					state_q <= last_q ? ST_F1 : ST_IDLE;
				end
				ST_F1: begin
					if (seen_q[1:0] != 2'd0)
						h_q <= (hash_q ^ word_q) * MIX_M;
					else
						h_q <= hash_q;
					state_q <= ST_F2;
				end
				ST_F2: begin
					h_q     <= (h_q ^ (h_q >> 13)) * MIX_M;
					state_q <= ST_F3;
				end
				ST_F3: begin
					h_q      <= h_q ^ (h_q >> 15);
					// rotate left by 15 of the final hash
					delta_q  <= {h_q[16:0] ^ h_q[31:15], h_q[31:17]};
					probe_q  <= '0;
					ans_q    <= 1'b1;
					add_ok_q <= !(count_q > capacity_q);
					state_q  <= ST_DONE;
					if (probes != '0 && (opcode_ok(op_q, count_q, capacity_q))) begin
						quo_q   <= h_q ^ (h_q >> 15);
						rem_q   <= '0;
						step_q  <= '0;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					// restoring division, one quotient bit per cycle
					if (rem_sh >= 33'(modulus))
						rem_q <= rem_sh - 33'(modulus);
					else
						rem_q <= rem_sh;
					quo_q  <= {quo_q[30:0], 1'b0};
					step_q <= step_q + 1'b1;
					if (step_q == 6'd31)
						state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_CHK;
				ST_CHK: begin
					h_q     <= h_q + delta_q;
					probe_q <= probe_q + 1'b1;
					if (op_q && !ram_rd) begin
						ans_q   <= 1'b0;
						state_q <= ST_DONE;
					end else if (probe_q + 1'b1 == probes) begin
						state_q <= ST_DONE;
					end else begin
						quo_q   <= h_q + delta_q;
						rem_q   <= '0;
						step_q  <= '0;
						state_q <= ST_MOD;
					end
				end
				ST_DONE: begin
					ov_q      <= 1'b1;
					chk_out_q <= op_q;
					if (op_q) begin
						ans_out_q <= ans_q;
					end else begin
						ans_out_q <= add_ok_q;
						if (add_ok_q && count_q != COUNT_MAX)
							count_q <= count_q + 1'b1;
					end
					hash_q  <= '0;
					word_q  <= '0;
					seen_q  <= '0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> dv/bloom_filter_insert_query_core_test.sv
//------------------------------------------------------------------------------
// bloom_filter_insert_query_core_test
// Streams add/check keys into the bloom filter core and compares every answer
// with a local hash-and-probe predictor. Covers the register extremes, short
// and surplus keys, and random valid/stall gaps on both channels.
//------------------------------------------------------------------------------
module bloom_filter_insert_query_core_test;
	import bfiq_pkg::*;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CHECK = 1'b1;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int FILTER_SIZE = 65536;
	localparam int KEY_LIMIT   = 256;
	localparam int PROBE_LIMIT = 30;
	localparam int ITEM_TARGET = 1650;
	localparam int CYCLE_LIMIT = 12000000;
	localparam int SETTLE      = 60;

	typedef struct packed {
		logic       op;
		logic [7:0] data;
		logic [8:0] len;
		logic       fin;
		logic       typed;
		logic       ans;
	} row_t;

	typedef struct packed {
		logic answer;
		logic was_check;
	} answer_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic opcode = 0;
	logic [7:0] key_byte = 0;
	logic [8:0] key_length = 0;
	logic last = 0;
	logic out_valid;
	logic out_stall = 0;
	logic answer;
	logic was_check;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;

	bloom_filter_insert_query_core dut (.*);

	always #4 clk = ~clk;

	// predictor state
	logic filter_bits [FILTER_SIZE];
	logic [31:0] hash_acc, word_buf;
	int unsigned bytes_seen, insert_count;
	logic [4:0] probe_cfg;
	logic [16:0] bits_cfg;
	logic [20:0] cap_cfg;

	answer_t pending_answers[$];
	int errors = 0;
	int cycles = 0;
	int items = 0;
	bit quiet = 0;
	int stall_left = 0;

	logic [7:0] key_buf [512];
	logic [7:0] saved_keys [16][64];
	int saved_len [16];
	int saved_n = 0;

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	task automatic apply_register(logic [1:0] idx, logic [31:0] val);
		case (idx)
			REG_HASH_COUNT: probe_cfg = val[4:0];
			REG_BIT_COUNT:  bits_cfg  = val[16:0];
			REG_CAPACITY:   cap_cfg   = val[20:0];
			default: ;
		endcase
	endtask

	// absorbs one request; returns 1 in has_ans when it closes a key
	task automatic bloom_predict(input logic op, input logic [7:0] b, input logic [8:0] len,
		input logic fin, output bit has_ans, output logic ans);
		logic [31:0] k, h, delta, modulus, pos;
		int unsigned probes;
		logic [1:0] slot;
		has_ans = 0;
		ans = 1;
		if (bytes_seen == 0)
			hash_acc = HASH_SEED ^ {23'd0, len};
		if (bytes_seen < len && bytes_seen < KEY_LIMIT) begin
			slot = bytes_seen[1:0];
			word_buf |= {24'd0, b} << (8 * slot);
			bytes_seen++;
			if (slot == 2'd3) begin
				k = word_buf * MIX_M;
				k ^= k >> 24;
				k = k * MIX_M;
				hash_acc = (hash_acc * MIX_M) ^ k;
				word_buf = 0;
			end
		end
		if (!fin)
			return;
		h = hash_acc;
		if (bytes_seen[1:0] != 0)
			h = (h ^ word_buf) * MIX_M;
		h ^= h >> 13;
		h = h * MIX_M;
		h ^= h >> 15;
		delta = {h[16:0], h[31:17]};
		probes = (probe_cfg > PROBE_LIMIT) ? PROBE_LIMIT : probe_cfg;
		modulus = (bits_cfg == 0 || bits_cfg > FILTER_SIZE) ? FILTER_SIZE : bits_cfg;
		if (op == OP_ADD) begin
			if (insert_count > cap_cfg) begin
				ans = 0;
			end else begin
				for (int i = 0; i < probes; i++) begin
					pos = h % modulus;
					filter_bits[pos] = 1;
					h += delta;
				end
				if (insert_count < COUNT_MAX)
					insert_count++;
			end
		end else begin
			for (int i = 0; i < probes; i++) begin
				pos = h % modulus;
				if (!filter_bits[pos]) begin
					ans = 0;
					break;
				end
				h += delta;
			end
		end
		hash_acc = 0;
		word_buf = 0;
		bytes_seen = 0;
		has_ans = 1;
	endtask

	task automatic send_request(logic op, logic [7:0] b, logic [8:0] len, logic fin,
		logic typed = 0, logic tans = 0);
		bit has;
		logic ans;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		key_byte <= b;
		key_length <= len;
		last <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bloom_predict(op, b, len, fin, has, ans);
		if (has)
			pending_answers.push_back('{answer: typed ? tans : ans, was_check: op});
		items++;
	endtask

	task automatic wait_idle();
		in_valid <= 0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		apply_register(idx, val);
	endtask

	// key of len bytes, sending nsend items, last on the final one
	task automatic send_key(logic op, int len, int nsend);
		for (int i = 0; i < nsend; i++)
			send_request(op, key_buf[i], len[8:0], i == nsend - 1);
	endtask

	task automatic random_phase(int count);
		int stop, len, nsend, sel, kind;
		logic op;
		stop = items + count;
		while (items < stop) begin
			kind = $urandom_range(0, 99);
			op = 1'($urandom_range(0, 1));
			sel = $urandom_range(0, 99);
			len = (sel < 88) ? $urandom_range(0, 12) :
				(sel < 98) ? $urandom_range(13, 64) : $urandom_range(250, 511);
			for (int i = 0; i < 512; i++)
				key_buf[i] = 8'($urandom_range(0, 255));
			if (op == OP_CHECK && saved_n > 0 && $urandom_range(0, 1)) begin
				sel = $urandom_range(0, saved_n - 1);
				len = saved_len[sel];
				for (int i = 0; i < len; i++)
					key_buf[i] = saved_keys[sel][i];
			end
			nsend = (len == 0) ? 1 : (len > KEY_LIMIT ? KEY_LIMIT + 1 : len);
			if (kind >= 85) begin
				// broken sequences: short key or surplus bytes
				nsend = (kind < 93 && len > 1) ? $urandom_range(1, len - 1)
					: nsend + $urandom_range(1, 4);
				if (nsend > 300)
					nsend = 300;
			end
			if (kind == 99) begin
				// length field wanders mid key
				send_request(op, key_buf[0], 9'($urandom_range(0, 511)), 1'b0);
			end
			send_key(op, len, nsend);
			if (op == OP_ADD && len <= 64 && kind < 85) begin
				if (saved_n < 16) begin
					sel = saved_n;
					saved_n++;
				end else begin
					sel = $urandom_range(0, 15);
				end
				saved_len[sel] = len;
				for (int i = 0; i < len; i++)
					saved_keys[sel][i] = key_buf[i];
			end
		end
	endtask

	row_t directed [21];

	always @(posedge clk) begin
		answer_t e;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected answer", answer, -1);
			end else begin
				e = pending_answers.pop_front();
				if (answer !== e.answer)
					report_mismatch("answer", answer, e.answer);
				if (was_check !== e.was_check)
					report_mismatch("was_check", was_check, e.was_check);
			end
		end
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= !quiet && $urandom_range(0, 1);
			stall_left <= $urandom_range(1, 14);
		end
	end

	initial begin
		for (int i = 0; i < FILTER_SIZE; i++)
			filter_bits[i] = 0;
		hash_acc = 0;
		word_buf = 0;
		bytes_seen = 0;
		insert_count = 0;
		probe_cfg = 7;
		bits_cfg = 17'd65536;
		cap_cfg = 21'd4096;

		directed = '{
			'{OP_CHECK, 8'h00, 9'd0,   1'b1, 1'b1, 1'b0},  // empty store
			'{OP_ADD,   8'hFF, 9'd0,   1'b1, 1'b1, 1'b1},  // empty key
			'{OP_CHECK, 8'h00, 9'd0,   1'b1, 1'b1, 1'b1},
			'{OP_ADD,   8'h00, 9'd4,   1'b0, 1'b0, 1'b0},
			'{OP_ADD,   8'hFF, 9'd4,   1'b0, 1'b0, 1'b0},
			'{OP_ADD,   8'h80, 9'd4,   1'b0, 1'b0, 1'b0},
			'{OP_ADD,   8'h7F, 9'd4,   1'b1, 1'b1, 1'b1},
			'{OP_CHECK, 8'h00, 9'd4,   1'b0, 1'b0, 1'b0},
			'{OP_CHECK, 8'hFF, 9'd4,   1'b0, 1'b0, 1'b0},
			'{OP_CHECK, 8'h80, 9'd4,   1'b0, 1'b0, 1'b0},
			'{OP_CHECK, 8'h7F, 9'd4,   1'b1, 1'b1, 1'b1},
			'{OP_CHECK, 8'h01, 9'd5,   1'b0, 1'b0, 1'b0},  // short key
			'{OP_CHECK, 8'h02, 9'd5,   1'b0, 1'b0, 1'b0},
			'{OP_CHECK, 8'h03, 9'd5,   1'b1, 1'b0, 1'b0},
			'{OP_ADD,   8'hAA, 9'd1,   1'b0, 1'b0, 1'b0},  // surplus bytes
			'{OP_ADD,   8'h55, 9'd1,   1'b0, 1'b0, 1'b0},
			'{OP_ADD,   8'hC3, 9'd1,   1'b1, 1'b1, 1'b1},
			'{OP_ADD,   8'hFF, 9'd256, 1'b1, 1'b1, 1'b1},
			'{OP_CHECK, 8'h12, 9'd511, 1'b1, 1'b0, 1'b0},
			'{OP_ADD,   8'h7E, 9'd3,   1'b0, 1'b0, 1'b0},
			'{OP_ADD,   8'h81, 9'd3,   1'b1, 1'b1, 1'b1}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1;

		foreach (directed[i])
			send_request(directed[i].op, directed[i].data, directed[i].len, directed[i].fin,
				directed[i].typed, directed[i].ans);
		random_phase(250);

		// one probe at bit zero; capacity already exceeded
		wait_idle();
		write_register(REG_HASH_COUNT, 32'd1);
		write_register(REG_BIT_COUNT, 32'd1);
		write_register(REG_CAPACITY, 32'd0);
		write_register(REG_UNUSED, 32'hFFFFFFFF);
		random_phase(300);

		// no probes, full-size modulus, largest capacity
		wait_idle();
		write_register(REG_HASH_COUNT, 32'hFFFFFFE0);
		write_register(REG_BIT_COUNT, 32'h0);
		write_register(REG_CAPACITY, 32'hFFFFFFFF);
		random_phase(300);

		// probe count clamps at the limit, oversize modulus
		wait_idle();
		write_register(REG_HASH_COUNT, 32'd31);
		write_register(REG_BIT_COUNT, 32'h0001FFFF);
		write_register(REG_CAPACITY, 32'd1048576);
		random_phase(250);

		wait_idle();
		write_register(REG_HASH_COUNT, 32'd30);
		write_register(REG_BIT_COUNT, 32'd65536);
		random_phase(200);

		wait_idle();
		write_register(REG_HASH_COUNT, $urandom_range(2, 12));
		write_register(REG_BIT_COUNT, $urandom_range(64, 4096));
		write_register(REG_CAPACITY, $urandom_range(0, 200));
		quiet = 1;
		random_phase(ITEM_TARGET - items);

		wait_idle();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
